@@ src/anti_replay_sequence_window_macros.svh @@
// assertion macros for the anti-replay window datapath
`ifndef ANTI_REPLAY_SEQUENCE_WINDOW_MACROS_SVH
`define ANTI_REPLAY_SEQUENCE_WINDOW_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define ARSW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("arsw assertion failed");

// consequence that must hold in the cycle after the trigger
`define ARSW_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("arsw assertion failed");

`else

`define ARSW_ASSERT(lbl, clk, rst_n, prop)
`define ARSW_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

@@ src/arsw_pkg.sv @@
// types, codes and constants of the anti-replay window
package arsw_pkg;

    localparam int SEQ_W            = 64;
    localparam int WORD_BITS        = 64;
    localparam int BIT_W            = 6;
    localparam int OP_W             = 2;
    localparam int VERDICT_W        = 3;
    localparam int WINDOW_WORDS_DEF = 16;
    localparam int EXHAUST_MARGIN   = 1024;

    localparam logic [SEQ_W-1:0] EXHAUST_BOUNDARY = '1 - SEQ_W'(EXHAUST_MARGIN);

    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_COMMIT = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_FRESH      = 3'd0,
        V_BAD_NUMBER = 3'd1,
        V_TOO_OLD    = 3'd2,
        V_DUPLICATE  = 3'd3,
        V_NOT_CHECK  = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACT,
        ST_CHK_RD,
        ST_RMW,
        ST_PRIME,
        ST_SLIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     eval;
        logic     set_verdict;
        verdict_t verdict;
        logic     verdict_from_bit;
        logic     first_commit;
        logic     wipe;
        logic     clear_all;
        logic     rd_age;
        logic     rmw_wr;
        logic     slide_start;
        logic     prime;
        logic     slide_step;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            newer;
        logic            age_far;
        logic            dist_far;
        logic            started;
        logic            seen_bit;
        logic            dst_zero;
        logic            out_busy;
    } status_t;

endpackage

@@ src/anti_replay_sequence_window.sv @@
// top level of the anti-replay window for 64-bit sequence numbers
//
//  channel   dir  tdata                       tuser
//  s_*       in   [63:0] seq_num              [1:0] op
//  m_*       out  [0] permitted, [3:1] verdict  -
//
// a check passes eval and act, plus a bitmap read for a number in the window;
// an older commit in the window adds a read-modify-write, and a newer commit
// within the window rewrites the bitmap one word per cycle through the ram port
// the input is taken again in the cycle after the result is loaded
// a stalled result holds in the output register; the next word is accepted
// meanwhile and its result waits until that register is free
// reset empties the window at once through per-word valid bits
module anti_replay_sequence_window #(
    parameter int WINDOW_WORDS = arsw_pkg::WINDOW_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seq_num
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] permitted, [3:1] verdict, [7:4] zero
);

    import arsw_pkg::*;

    cmd_t                 cmd;
    status_t              status;
    logic                 permitted;
    logic [VERDICT_W-1:0] verdict;

    arsw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    arsw_dp #(
        .WINDOW_WORDS(WINDOW_WORDS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_op        (s_tuser),
        .in_seq       (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_permitted(permitted),
        .out_verdict  (verdict)
    );

    assign m_tdata = {4'b0000, verdict, permitted};

endmodule

@@ src/arsw_ram.sv @@
// generic single-write, single-read ram with registered read data
module arsw_ram #(
    parameter int WIDTH = arsw_pkg::WORD_BITS,
    parameter int DEPTH = arsw_pkg::WINDOW_WORDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/arsw_ctrl.sv @@
// controller state machine of the anti-replay window
module arsw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  arsw_pkg::status_t status,
    output arsw_pkg::cmd_t    cmd
);

    import arsw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.verdict = V_NOT_CHECK;
        in_ready    = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                state_next      = ST_DONE;
                cmd.set_verdict = 1'b1;
                case (status.op)
                    OP_CHECK:
                    begin
                        if (status.bad)
                        begin
                            cmd.verdict = V_BAD_NUMBER;
                        end
                        else if (!status.started || status.newer)
                        begin
                            cmd.verdict = V_FRESH;
                        end
                        else if (status.age_far)
                        begin
                            cmd.verdict = V_TOO_OLD;
                        end
                        else
                        begin
                            cmd.set_verdict = 1'b0;
                            cmd.rd_age      = 1'b1;
                            state_next      = ST_CHK_RD;
                        end
                    end
                    OP_COMMIT:
                    begin
                        if (!status.started)
                        begin
                            cmd.first_commit = 1'b1;
                        end
                        else if (status.newer)
                        begin
                            if (status.dist_far)
                            begin
                                cmd.wipe = 1'b1;
                            end
                            else
                            begin
                                cmd.slide_start = 1'b1;
                                state_next      = ST_PRIME;
                            end
                        end
                        else if (!status.age_far)
                        begin
                            cmd.rd_age = 1'b1;
                            state_next = ST_RMW;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    default:
                    begin
                        cmd.verdict = V_NOT_CHECK;
                    end
                endcase
            end
            ST_CHK_RD:
            begin
                cmd.verdict_from_bit = 1'b1;
                state_next           = ST_DONE;
            end
            ST_RMW:
            begin
                cmd.rmw_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = ST_SLIDE;
            end
            ST_SLIDE:
            begin
                cmd.slide_step = 1'b1;
                if (status.dst_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/arsw_dp.sv @@
// datapath of the anti-replay window: sequence registers, bitmap and result word
`include "anti_replay_sequence_window_macros.svh"

module arsw_dp #(
    parameter int WINDOW_WORDS = arsw_pkg::WINDOW_WORDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [arsw_pkg::OP_W-1:0]        in_op,
    input  logic [arsw_pkg::SEQ_W-1:0]       in_seq,
    input  arsw_pkg::cmd_t                   cmd,
    output arsw_pkg::status_t                status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_permitted,
    output logic [arsw_pkg::VERDICT_W-1:0]   out_verdict
);

    import arsw_pkg::*;

    localparam int IDX_W = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
    localparam int SRC_W = IDX_W + 2;
    localparam int AGE_W = BIT_W + IDX_W;
    localparam int HI_W  = SEQ_W - BIT_W;
    localparam int SH_W  = BIT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_WORDS - 1);

    logic [OP_W-1:0]         op_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic [SEQ_W-1:0]        highest_reg;
    logic                    started_reg;
    logic [WINDOW_WORDS-1:0] valid_reg;
    logic [WINDOW_WORDS-1:0] valid_next;
    logic                    bad_reg;
    logic                    newer_reg;
    logic                    age_far_reg;
    logic                    dist_far_reg;
    logic [AGE_W-1:0]        age_lo_reg;
    logic [AGE_W-1:0]        dist_lo_reg;
    logic [SRC_W-1:0]        src_reg;
    logic [IDX_W-1:0]        dst_reg;
    logic [WORD_BITS-1:0]    cur_reg;
    logic                    rd_ok_reg;
    logic                    rd_ok_next;
    verdict_t                verdict_reg;
    logic                    out_valid_reg;
    logic                    out_permitted_reg;
    verdict_t                out_verdict_reg;

    logic [SEQ_W:0]          age_diff;
    logic [SEQ_W-1:0]        dist_diff;
    logic [IDX_W-1:0]        age_word;
    logic [BIT_W-1:0]        age_bit;
    logic [IDX_W-1:0]        shift_words;
    logic [BIT_W-1:0]        shift_bits;
    logic [SRC_W-1:0]        src_first;
    logic [IDX_W-1:0]        raddr;
    logic                    rd_req_ok;
    logic [WORD_BITS-1:0]    ram_rdata;
    logic [WORD_BITS-1:0]    rdata_eff;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [WORD_BITS-1:0]    wdata;

    // borrow out of highest - seq means the number is newer
    assign age_diff  = {1'b0, highest_reg} - {1'b0, seq_reg};
    assign dist_diff = seq_reg - highest_reg;

    assign age_word    = age_lo_reg[AGE_W-1:BIT_W];
    assign age_bit     = age_lo_reg[BIT_W-1:0];
    assign shift_words = dist_lo_reg[AGE_W-1:BIT_W];
    assign shift_bits  = dist_lo_reg[BIT_W-1:0];
    assign src_first   = SRC_W'(WINDOW_WORDS - 1) - SRC_W'(shift_words);

    // never-written or out-of-window words read as zero
    assign rdata_eff = rd_ok_reg ? ram_rdata : '0;

    always_comb
    begin
        raddr     = src_reg[IDX_W-1:0];
        rd_req_ok = 1'b0;
        if (cmd.rd_age)
        begin
            raddr     = age_word;
            rd_req_ok = 1'b1;
        end
        else if (cmd.slide_start)
        begin
            raddr     = src_first[IDX_W-1:0];
            rd_req_ok = 1'b1;
        end
        else if (cmd.prime || cmd.slide_step)
        begin
            raddr     = src_reg[IDX_W-1:0];
            rd_req_ok = !src_reg[SRC_W-1];
        end
        rd_ok_next = rd_req_ok && valid_reg[raddr];
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.first_commit || cmd.wipe)
        begin
            we    = 1'b1;
            wdata = WORD_BITS'(1);
        end
        else if (cmd.rmw_wr)
        begin
            we    = 1'b1;
            waddr = age_word;
            wdata = rdata_eff | (WORD_BITS'(1) << age_bit);
        end
        else if (cmd.slide_step)
        begin
            we    = 1'b1;
            waddr = dst_reg;
            // upper part from the word below, bit 0 marked on the last word
            wdata = (cur_reg << shift_bits)
                  | (rdata_eff >> (SH_W'(WORD_BITS) - SH_W'(shift_bits)))
                  | ((dst_reg == '0) ? WORD_BITS'(1) : '0);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clear_all || cmd.wipe)
        begin
            valid_next = '0;
        end
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    arsw_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(WINDOW_WORDS)
    ) u_bitmap (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            highest_reg   <= '0;
            started_reg   <= 1'b0;
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_ok_reg <= rd_ok_next;
            if (cmd.clear_all)
            begin
                highest_reg <= '0;
                started_reg <= 1'b0;
            end
            else if (cmd.first_commit)
            begin
                highest_reg <= seq_reg;
                started_reg <= 1'b1;
            end
            else if (cmd.wipe || cmd.slide_start)
            begin
                highest_reg <= seq_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= in_op;
            seq_reg <= in_seq;
        end
        if (cmd.eval)
        begin
            bad_reg      <= (seq_reg == '0) || (seq_reg > EXHAUST_BOUNDARY);
            newer_reg    <= age_diff[SEQ_W];
            age_far_reg  <= age_diff[SEQ_W-1:BIT_W] >= HI_W'(WINDOW_WORDS);
            dist_far_reg <= dist_diff[SEQ_W-1:BIT_W] >= HI_W'(WINDOW_WORDS);
            age_lo_reg   <= age_diff[AGE_W-1:0];
            dist_lo_reg  <= dist_diff[AGE_W-1:0];
        end
        if (cmd.slide_start)
        begin
            src_reg <= src_first - SRC_W'(1);
            dst_reg <= LAST_IDX;
        end
        else if (cmd.prime || cmd.slide_step)
        begin
            src_reg <= src_reg - SRC_W'(1);
        end
        if (cmd.slide_step)
        begin
            dst_reg <= dst_reg - IDX_W'(1);
        end
        if (cmd.prime || cmd.slide_step)
        begin
            cur_reg <= rdata_eff;
        end
        if (cmd.set_verdict)
        begin
            verdict_reg <= cmd.verdict;
        end
        else if (cmd.verdict_from_bit)
        begin
            verdict_reg <= rdata_eff[age_bit] ? V_DUPLICATE : V_FRESH;
        end
        if (cmd.load_out)
        begin
            out_permitted_reg <= (verdict_reg == V_FRESH);
            out_verdict_reg   <= verdict_reg;
        end
    end

    always_comb
    begin
        status          = '0;
        status.op       = op_reg;
        status.bad      = bad_reg;
        status.newer    = newer_reg;
        status.age_far  = age_far_reg;
        status.dist_far = dist_far_reg;
        status.started  = started_reg;
        status.seen_bit = rdata_eff[age_bit];
        status.dst_zero = (dst_reg == '0);
        status.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign out_permitted = out_permitted_reg;
    assign out_verdict   = out_verdict_reg;

    `ARSW_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear_all, (valid_reg == '0) && !started_reg)
    `ARSW_ASSERT(a_load_when_free, clk, rst_n, cmd.load_out |-> !status.out_busy)
    `ARSW_ASSERT(a_permit_is_fresh, clk, rst_n, (out_valid_reg && out_permitted_reg) |-> (out_verdict_reg == V_FRESH))
    `ARSW_ASSERT_NEXT(a_slide_marks_top, clk, rst_n, cmd.slide_step && status.dst_zero, valid_reg[0])

endmodule
